### rtl/bmp_stream_blitter_unit_defines.svh
`ifndef BMP_STREAM_BLITTER_UNIT_DEFINES_SVH
`define BMP_STREAM_BLITTER_UNIT_DEFINES_SVH

// Checks that a condition in this cycle implies another in the same cycle.
`define BSB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsb assertion failed");

// Checks that a condition in this cycle implies another in the next cycle.
`define BSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsb assertion failed");

`endif

### rtl/bsb_pkg.sv
package bsb_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned SCREEN_LIMIT = 4096;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] HDR_END = 32'd30;
  localparam logic [4:0] OFS_DATA = 5'h0A;
  localparam logic [4:0] OFS_WIDTH = 5'h12;
  localparam logic [4:0] OFS_HEIGHT = 5'h16;
  localparam logic [4:0] OFS_DEPTH = 5'h1C;
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;
  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_BAD_SIG = 2'd1;
  localparam logic [1:0] KIND_BAD_HDR = 2'd2;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_SCREEN_W = 2'd2;
  localparam logic [1:0] REG_SCREEN_H = 2'd3;

  typedef struct packed {
    logic [31:0] byte_index;
    logic [31:0] data_start;
    logic [31:0] img_width;
    logic [31:0] img_height;
    logic [15:0] depth_bits;
    logic [12:0] file_row;
    logic [12:0] column;
    logic [1:0]  byte_in_pixel;
    logic [1:0]  pad_left;
    logic [23:0] pixel_accum;
    logic        halted;
  } parse_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] column;
    logic [11:0] row;
    logic [31:0] color;
    logic        final_pixel;
  } entry_t;

  typedef struct packed {
    logic [11:0] offset_x;
    logic [11:0] offset_y;
    logic [12:0] limit_w;
    logic [12:0] limit_h;
  } cfg_t;

endpackage

### rtl/bsb_ifs.sv
interface bsb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_byte;
  modport source(output valid, output file_byte, output first_byte, input ready);
  modport sink(input valid, input file_byte, input first_byte, output ready);
endinterface

interface bsb_pixel_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [31:0] color;
  logic        final_pixel;
  modport source(output valid, output kind, output pixel_x, output pixel_y,
                 output color, output final_pixel, input ready);
  modport sink(input valid, input kind, input pixel_x, input pixel_y,
               input color, input final_pixel, output ready);
endinterface

interface bsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/bsb_front.sv
module bsb_front (
  input  logic              clk,
  input  logic              rst,
  bsb_byte_if.sink          byte_ch,
  input  logic              queue_full,
  output logic              push,
  output bsb_pkg::entry_t   push_entry
);

  bsb_pkg::parse_t st;
  bsb_pkg::parse_t st_next;
  bsb_pkg::parse_t cur;
  logic            accept;
  logic            produce;
  logic [7:0]      b;
  logic [31:0]     idx;
  logic [4:0]      hdr_idx;
  logic [1:0]      lane;
  logic [31:0]     lane_word;
  logic [23:0]     acc_word;
  logic [31:0]     color;
  logic            pixel_ready;
  logic            fin;
  logic [12:0]     col_inc;

  assign byte_ch.ready = !queue_full;
  assign accept = byte_ch.valid && byte_ch.ready;
  assign b = byte_ch.file_byte;

  always_comb begin
    cur = byte_ch.first_byte ? '0 : st;
    st_next = cur;
    produce = 1'b0;
    push_entry = '0;
    idx = cur.byte_index;
    hdr_idx = idx[4:0];
    lane = 2'(hdr_idx - bsb_pkg::OFS_DATA);
    lane_word = {24'b0, b} << {lane, 3'b000};
    acc_word = {16'b0, b} << {cur.byte_in_pixel, 3'b000};
    color = '0;
    pixel_ready = 1'b0;
    fin = 1'b0;
    col_inc = cur.column + 13'd1;
    if (!cur.halted) begin
      if (idx != '1) begin
        st_next.byte_index = idx + 32'd1;
      end
      if (idx < bsb_pkg::HDR_END) begin
        if (hdr_idx == 5'd0) begin
          st_next.pixel_accum = {16'b0, b};
        end else if (hdr_idx == 5'd1) begin
          if (cur.pixel_accum != {16'b0, bsb_pkg::SIG_B} || b != bsb_pkg::SIG_M) begin
            st_next.halted = 1'b1;
            produce = 1'b1;
            push_entry.kind = bsb_pkg::KIND_BAD_SIG;
          end
        end else if (hdr_idx inside {[bsb_pkg::OFS_DATA : bsb_pkg::OFS_DATA + 5'd3]}) begin
          st_next.data_start = cur.data_start | lane_word;
        end else if (hdr_idx inside {[bsb_pkg::OFS_WIDTH : bsb_pkg::OFS_WIDTH + 5'd3]}) begin
          st_next.img_width = cur.img_width | lane_word;
        end else if (hdr_idx inside {[bsb_pkg::OFS_HEIGHT : bsb_pkg::OFS_HEIGHT + 5'd3]}) begin
          st_next.img_height = cur.img_height | lane_word;
        end else if (hdr_idx == bsb_pkg::OFS_DEPTH) begin
          st_next.depth_bits = cur.depth_bits | {8'b0, b};
        end else if (hdr_idx == bsb_pkg::OFS_DEPTH + 5'd1) begin
          st_next.depth_bits = cur.depth_bits | {b, 8'b0};
          st_next.pixel_accum = '0;
          if (cur.data_start < bsb_pkg::HDR_END || cur.img_width == '0 ||
              cur.img_height == '0 || cur.img_width > 32'(bsb_pkg::MAX_DIM) ||
              cur.img_height > 32'(bsb_pkg::MAX_DIM)) begin
            st_next.halted = 1'b1;
            produce = 1'b1;
            push_entry.kind = bsb_pkg::KIND_BAD_HDR;
          end else if (st_next.depth_bits != bsb_pkg::DEPTH_24 &&
                       st_next.depth_bits != bsb_pkg::DEPTH_32) begin
            st_next.halted = 1'b1;
          end
        end
      end else if (idx >= cur.data_start) begin
        if (cur.depth_bits == bsb_pkg::DEPTH_24) begin
          if (cur.pad_left != 2'd0) begin
            st_next.pad_left = cur.pad_left - 2'd1;
          end else if (cur.byte_in_pixel < 2'd2) begin
            st_next.pixel_accum = cur.pixel_accum | acc_word;
            st_next.byte_in_pixel = cur.byte_in_pixel + 2'd1;
          end else begin
            pixel_ready = 1'b1;
            color = {bsb_pkg::ALPHA_OPAQUE, b, cur.pixel_accum[15:0]};
          end
        end else begin
          if (cur.byte_in_pixel < 2'd3) begin
            st_next.pixel_accum = cur.pixel_accum | acc_word;
            st_next.byte_in_pixel = cur.byte_in_pixel + 2'd1;
          end else begin
            pixel_ready = 1'b1;
            color = {b, cur.pixel_accum};
          end
        end
      end
      if (pixel_ready) begin
        fin = (cur.file_row == cur.img_height[12:0] - 13'd1) &&
              (cur.column == cur.img_width[12:0] - 13'd1);
        st_next.byte_in_pixel = 2'd0;
        st_next.pixel_accum = '0;
        if (col_inc >= cur.img_width[12:0]) begin
          st_next.column = '0;
          st_next.file_row = cur.file_row + 13'd1;
          st_next.pad_left = (cur.depth_bits == bsb_pkg::DEPTH_24) ? cur.img_width[1:0] : 2'd0;
        end else begin
          st_next.column = col_inc;
        end
        if (fin) begin
          st_next.halted = 1'b1;
        end
        produce = 1'b1;
        push_entry.kind = bsb_pkg::KIND_PIXEL;
        push_entry.column = cur.column[11:0];
        push_entry.row = 12'(cur.img_height[12:0] - 13'd1 - cur.file_row);
        push_entry.color = color;
        push_entry.final_pixel = fin;
      end
    end
  end

  assign push = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

### rtl/bsb_queue.sv
module bsb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bsb_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            empty,
  output logic            full,
  output bsb_pkg::entry_t head
);

  bsb_pkg::entry_t                   mem [bsb_pkg::Q_DEPTH];
  logic [bsb_pkg::Q_PTR_W-1:0]       wr_ptr;
  logic [bsb_pkg::Q_PTR_W-1:0]       rd_ptr;
  logic [bsb_pkg::Q_CNT_W-1:0]       count;

  assign empty = (count == '0);
  assign full = (count == bsb_pkg::Q_CNT_W'(bsb_pkg::Q_DEPTH));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/bsb_back.sv
module bsb_back (
  input  logic            clk,
  input  logic            rst,
  input  bsb_pkg::cfg_t   cfg,
  input  logic            empty,
  input  bsb_pkg::entry_t head,
  output logic            pop,
  bsb_pixel_if.source     pixel_ch
);

  logic        valid;
  logic [12:0] x;
  logic [12:0] y;
  logic        visible;
  logic        load_free;

  assign load_free = !valid || pixel_ch.ready;
  assign pop = !empty && load_free;
  assign x = {1'b0, cfg.offset_x} + {1'b0, head.column};
  assign y = {1'b0, cfg.offset_y} + {1'b0, head.row};
  assign visible = (head.kind != bsb_pkg::KIND_PIXEL) ||
                   (x < cfg.limit_w && y < cfg.limit_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop && visible) begin
      valid <= 1'b1;
    end else if (pixel_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && visible) begin
      pixel_ch.kind <= head.kind;
      pixel_ch.pixel_x <= (head.kind == bsb_pkg::KIND_PIXEL) ? x[11:0] : 12'd0;
      pixel_ch.pixel_y <= (head.kind == bsb_pkg::KIND_PIXEL) ? y[11:0] : 12'd0;
      pixel_ch.color <= head.color;
      pixel_ch.final_pixel <= head.final_pixel;
    end
  end

  assign pixel_ch.valid = valid;

endmodule

### rtl/bmp_stream_blitter_unit.sv
// Parses a BMP file arriving one byte per item and writes its 24-bit or 32-bit pixels to the
// screen as ARGB items, clipped to the screen size, with error items for a bad signature or
// header; an unsupported pixel depth stops the parse with no item. It takes one byte every
// cycle and delivers at most one result per byte; the front parser and the output stage
// are parted by a four-entry queue, so the byte side stalls only when that queue is full;
// a result enters the queue as its byte is accepted, then the output register once free.
// Configuration writes are accepted in every cycle and must only be made while the block is idle.
module bmp_stream_blitter_unit (
  input  logic        clk,
  input  logic        rst,
  bsb_byte_if.sink    byte_ch,
  bsb_pixel_if.source pixel_ch,
  bsb_cfg_if.sink     cfg_ch
);

  bsb_pkg::cfg_t   cfg;
  bsb_pkg::entry_t push_entry;
  bsb_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  logic [12:0]     clamped;

  assign cfg_ch.ready = 1'b1;
  assign clamped = (cfg_ch.data > 13'(bsb_pkg::SCREEN_LIMIT)) ?
                   13'(bsb_pkg::SCREEN_LIMIT) : cfg_ch.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x <= '0;
      cfg.offset_y <= '0;
      cfg.limit_w <= 13'd1024;
      cfg.limit_h <= 13'd768;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bsb_pkg::REG_OFFSET_X: cfg.offset_x <= cfg_ch.data[11:0];
        bsb_pkg::REG_OFFSET_Y: cfg.offset_y <= cfg_ch.data[11:0];
        bsb_pkg::REG_SCREEN_W: cfg.limit_w <= clamped;
        bsb_pkg::REG_SCREEN_H: cfg.limit_h <= clamped;
        default: ;
      endcase
    end
  end

  bsb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  bsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .empty      (empty),
    .full       (full),
    .head       (head)
  );

  bsb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .pixel_ch (pixel_ch)
  );

endmodule

### rtl/bsb_checker.sv
`include "bmp_stream_blitter_unit_defines.svh"

module bsb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [11:0] pixel_x,
  input logic [11:0] pixel_y,
  input logic [31:0] color,
  input logic        final_pixel,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `BSB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(color) && $stable(pixel_x) && $stable(pixel_y) && $stable(kind))
  `BSB_ASSERT_NOW(a_err_payload, clk, rst, out_valid && kind != bsb_pkg::KIND_PIXEL, pixel_x == 12'd0 && pixel_y == 12'd0 && color == 32'd0 && !final_pixel)
  `BSB_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind bmp_stream_blitter_unit bsb_checker u_bsb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (pixel_ch.valid),
  .out_ready   (pixel_ch.ready),
  .kind        (pixel_ch.kind),
  .pixel_x     (pixel_ch.pixel_x),
  .pixel_y     (pixel_ch.pixel_y),
  .color       (pixel_ch.color),
  .final_pixel (pixel_ch.final_pixel),
  .cfg_valid   (cfg_ch.valid),
  .cfg_ready   (cfg_ch.ready)
);
